[design/dlts_pkg.sv]
`default_nettype none
package dlts_pkg;
	localparam int MAX_TASKS_DEF  = 16;
	localparam int TICK_WIDTH_DEF = 16;
	localparam int RESULT_CAP     = 16;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_DISP   = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  task_number;
		logic [15:0] first_delay;
		logic [15:0] repeat_period;
	} cmd_t;

	typedef struct packed {
		logic [7:0] ran_task;
		logic       ran_valid;
		logic [1:0] status;
		logic       last;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture command
		logic tick;       // count head down
		logic clear;      // empty queue
		logic drop;       // start head removal
		logic take_head;  // latch head for dispatch and drop it
		logic ins_start;  // begin insertion walk
		logic ins_step;   // one step of walk or shift
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic head_due;
		logic head_periodic;
		logic busy;       // shift or walk in progress
	} sts_t;
endpackage
`default_nettype wire

[design/dlts_datapath.sv]
`default_nettype none
module dlts_datapath #(
	parameter int MAX_TASKS  = dlts_pkg::MAX_TASKS_DEF,
	parameter int TICK_WIDTH = dlts_pkg::TICK_WIDTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  dlts_pkg::cmd_t     cmd,
	input  dlts_pkg::ctl_t     ctl,
	output dlts_pkg::sts_t     sts,
	output logic [7:0]         head_task
);
	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int LW = $clog2(MAX_TASKS + 1);
	localparam int SW = TICK_WIDTH + 1;
	localparam logic [LW-1:0] MAXL = LW'(MAX_TASKS);

	// walk phases
	localparam logic [1:0] W_IDLE = 2'd0;
	localparam logic [1:0] W_FIND = 2'd1;
	localparam logic [1:0] W_SHIFT = 2'd2;
	localparam logic [1:0] W_DROP = 2'd3;

	logic [7:0]            task_q   [MAX_TASKS];
	logic [TICK_WIDTH-1:0] delta_q  [MAX_TASKS];
	logic [15:0]           period_q [MAX_TASKS];
	logic [LW-1:0]         len_q;
	logic [1:0]            walk_q;
	logic [LW-1:0]         pos_q;
	logic [LW-1:0]         j_q;
	logic [SW-1:0]         before_q;
	logic [7:0]            itask_q;
	logic [TICK_WIDTH-1:0] idelay_q;
	logic [15:0]           iperiod_q;
	logic [7:0]            htask_q;

	logic [SW-1:0]         upto;
	logic [TICK_WIDTH-1:0] sat_first, sat_per, new_delta;
	logic [IW-1:0]         pos_i, j_i, jm_i;

	// saturate a 16 bit delay to the tick range
	function automatic logic [TICK_WIDTH-1:0] sat(input logic [15:0] v);
		logic [31:0] w;
		logic [31:0] m;
		begin
			w = 32'(v);
			m = (TICK_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TICK_WIDTH) - 32'd1);
			sat = TICK_WIDTH'((w > m) ? m : w);
		end
	endfunction

	assign sat_first = sat(cmd.first_delay);
	assign sat_per   = sat(period_q[0]);
	assign pos_i     = pos_q[IW-1:0];
	assign j_i       = j_q[IW-1:0];
	assign jm_i      = IW'(j_q - LW'(1));
	assign upto      = before_q + SW'(delta_q[pos_i]);
	assign new_delta = TICK_WIDTH'(SW'(idelay_q) - before_q);

	assign sts.empty         = (len_q == '0);
	assign sts.full          = (len_q >= MAXL);
	assign sts.head_due      = (len_q != '0) && (delta_q[0] == '0);
	assign sts.head_periodic = (period_q[0] != 16'd0);
	assign sts.busy          = (walk_q != W_IDLE);
	assign head_task         = htask_q;

	// control state of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			walk_q <= W_IDLE;
		end else begin
			priority if (ctl.clear) begin
				len_q <= '0;
			end else if (ctl.drop || ctl.take_head) begin
				walk_q <= W_DROP;
			end else if (ctl.ins_start) begin
				walk_q <= W_FIND;
			end else if (ctl.ins_step) begin
				unique case (walk_q)
					W_FIND: begin
						if (pos_q >= len_q || SW'(idelay_q) <= upto)
							walk_q <= W_SHIFT;
					end
					W_SHIFT: begin
						if (j_q <= pos_q) begin
							walk_q <= W_IDLE;
							len_q  <= len_q + LW'(1);
						end
					end
					W_DROP: begin
						if (j_q + LW'(1) >= len_q) begin
							walk_q <= W_IDLE;
							len_q  <= len_q - LW'(1);
						end
					end
					default: walk_q <= W_IDLE;
				endcase
			end
		end
	end

	// entry store and walk registers
	always_ff @(posedge clk) begin
		if (ctl.tick && len_q != '0 && delta_q[0] != '0)
			delta_q[0] <= delta_q[0] - TICK_WIDTH'(1);
		if (ctl.drop || ctl.take_head) begin
			j_q      <= LW'(1);
			htask_q  <= task_q[0];
			itask_q  <= task_q[0];
			idelay_q <= sat_per;
			iperiod_q <= period_q[0];
		end
		if (ctl.ins_start) begin
			pos_q    <= '0;
			before_q <= '0;
			j_q      <= len_q;
			if (ctl.load) begin
				itask_q   <= cmd.task_number;
				idelay_q  <= sat_first;
				iperiod_q <= cmd.repeat_period;
			end
		end
		if (ctl.ins_step) begin
			unique case (walk_q)
				W_FIND: begin
					if (!(pos_q >= len_q || SW'(idelay_q) <= upto)) begin
						before_q <= upto;
						pos_q    <= pos_q + LW'(1);
					end
				end
				W_SHIFT: begin
					if (j_q > pos_q) begin
						// move one entry up
						task_q[j_i]   <= task_q[jm_i];
						delta_q[j_i]  <= delta_q[jm_i];
						period_q[j_i] <= period_q[jm_i];
						j_q <= j_q - LW'(1);
					end else begin
						task_q[pos_i]   <= itask_q;
						delta_q[pos_i]  <= new_delta;
						period_q[pos_i] <= iperiod_q;
						if (pos_q < len_q)
							delta_q[IW'(pos_q + LW'(1))] <=
								delta_q[IW'(pos_q + LW'(1))] - new_delta;
					end
				end
				W_DROP: begin
					if (j_q < len_q) begin
						// move one entry down
						task_q[jm_i]   <= task_q[j_i];
						delta_q[jm_i]  <= delta_q[j_i];
						period_q[jm_i] <= period_q[j_i];
					end
					j_q <= j_q + LW'(1);
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/dlts_ctrl.sv]
`default_nettype none
module dlts_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  dlts_pkg::cmd_t      cmd,
	input  dlts_pkg::sts_t      sts,
	input  wire  [7:0]          head_task,
	output logic                busy,
	output dlts_pkg::ctl_t      ctl,
	output logic                done,
	output dlts_pkg::res_t      result
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DROP  = 3'd1;
	localparam logic [2:0] S_INS   = 3'd2;
	localparam logic [2:0] S_DCHK  = 3'd3;
	localparam logic [2:0] S_DPOP  = 3'd4;
	localparam logic [2:0] S_DINS  = 3'd5;
	localparam logic [2:0] S_DEMIT = 3'd6;

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic       per_q;
	logic       done_q;
	dlts_pkg::res_t res_q;
	logic       accept;
	logic       done_d;
	logic [1:0] cmd_status;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// status of a command answered straight from idle
	assign cmd_status = (cmd.op == dlts_pkg::OP_REMOVE && sts.empty) ? dlts_pkg::ST_EMPTY :
		(cmd.op == dlts_pkg::OP_ADD && sts.full) ? dlts_pkg::ST_FULL : dlts_pkg::ST_OK;

	// command decode and dispatch control
	always_comb begin
		ctl = '0;
		ctl.ins_step = sts.busy;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.load = 1'b1;
					unique case (cmd.op)
						dlts_pkg::OP_TICK:   ctl.tick = 1'b1;
						dlts_pkg::OP_CLEAR:  ctl.clear = 1'b1;
						dlts_pkg::OP_REMOVE: ctl.drop = !sts.empty;
						dlts_pkg::OP_ADD:    ctl.ins_start = !sts.full;
						default: ;
					endcase
				end
			end
			S_DCHK: ctl.take_head = sts.head_due && (cnt_q < 5'(dlts_pkg::RESULT_CAP));
			S_DPOP: ctl.ins_start = !sts.busy && per_q;
			default: ;
		endcase
	end

	// result strobe for the next cycle
	always_comb begin
		done_d = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.op)
						dlts_pkg::OP_REMOVE: done_d = sts.empty;
						dlts_pkg::OP_ADD:    done_d = sts.full;
						dlts_pkg::OP_DISP:   done_d = 1'b0;
						default:             done_d = 1'b1;
					endcase
				end
			end
			S_DROP, S_INS: done_d = !sts.busy;
			S_DCHK:        done_d = !ctl.take_head && (cnt_q == '0);
			S_DEMIT:       done_d = 1'b1;
			default: ;
		endcase
	end

	// sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			per_q   <= 1'b0;
		end else begin
			done_q <= done_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '{ran_task: 8'd0, ran_valid: 1'b0,
							status: cmd_status, last: 1'b1};
						unique case (cmd.op)
							dlts_pkg::OP_REMOVE: begin
								if (!sts.empty)
									state_q <= S_DROP;
							end
							dlts_pkg::OP_ADD: begin
								if (!sts.full)
									state_q <= S_INS;
							end
							dlts_pkg::OP_DISP: begin
								cnt_q   <= '0;
								state_q <= S_DCHK;
							end
							default: ;
						endcase
					end
				end
				S_DROP, S_INS: begin
					if (!sts.busy)
						state_q <= S_IDLE;
				end
				S_DCHK: begin
					if (ctl.take_head) begin
						per_q   <= sts.head_periodic;
						state_q <= S_DPOP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DPOP: begin
					if (!sts.busy)
						state_q <= per_q ? S_DINS : S_DEMIT;
				end
				S_DINS: begin
					if (!sts.busy)
						state_q <= S_DEMIT;
				end
				S_DEMIT: begin
					// emit now; mark last if another due entry cannot follow
					res_q <= '{ran_task: head_task, ran_valid: 1'b1, status: dlts_pkg::ST_OK,
						last: !(sts.head_due && (cnt_q + 5'd1 < 5'(dlts_pkg::RESULT_CAP)))};
					cnt_q   <= cnt_q + 5'd1;
					state_q <= S_DCHK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/delta_list_task_scheduler.sv]
`default_nettype none
// Tick, clear and odd codes are answered straight from idle; add and remove walk the queue.
// Dispatch: a periodic task run costs more than a one-shot run, its time set by the
// single-entry shift of the queue; with nothing due, one result with ran_valid low is given.
// One command at a time: busy falls at or just after its last result strobe.
// Results appear one cycle on result with done high; the receiver cannot stall.
// Reset empties the queue at once; entry storage is not cleared.
module delta_list_task_scheduler #(
	parameter int MAX_TASKS  = dlts_pkg::MAX_TASKS_DEF,
	parameter int TICK_WIDTH = dlts_pkg::TICK_WIDTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  dlts_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output dlts_pkg::res_t  result
);
	dlts_pkg::ctl_t ctl;
	dlts_pkg::sts_t sts;
	logic [7:0]     head_task;

	dlts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .sts(sts),
		.head_task(head_task), .busy(busy), .ctl(ctl), .done(done), .result(result)
	);

	dlts_datapath #(.MAX_TASKS(MAX_TASKS), .TICK_WIDTH(TICK_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ctl(ctl), .sts(sts),
		.head_task(head_task)
	);
endmodule
`default_nettype wire
